// File: sv/sfp_pkg.sv
// Shared widths, reset values, codes and types of the stuffed frame parser.
`timescale 1ns / 1ps

package sfp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned AccW    = 17;
  localparam int unsigned ShiftW  = 3;
  localparam int unsigned StatusW = 3;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [ByteW-1:0] TagReset    = 8'hFF;
  localparam logic [LenW-1:0]  MaxLenReset = 16'd1024;
  localparam logic [AccW-1:0]  AccMax      = 17'h1FFFF;

  typedef enum logic [StatusW-1:0] {
    ST_CONSUMED  = 3'd0,
    ST_PAYLOAD   = 3'd1,
    ST_GOOD      = 3'd2,
    ST_BAD_ESC   = 3'd3,
    ST_LEN_LARGE = 3'd4,
    ST_CSUM_BAD  = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    REG_TAG     = 1'b0,
    REG_MAX_LEN = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] tag_byte;
    logic [LenW-1:0]  max_payload_len;
  } cfg_t;

  typedef struct packed {
    status_e          status;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] frame_id;
    logic [LenW-1:0]  frame_len;
  } res_t;

endpackage

// File: sv/sfp_ifs.sv
// Handshake interfaces for received bytes and parser result items.
`timescale 1ns / 1ps

interface sfp_rx_if;
  logic                        valid;
  logic                        ready;
  logic [sfp_pkg::ByteW-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfp_res_if;
  logic                        valid;
  logic                        ready;
  logic [sfp_pkg::StatusW-1:0] status;
  logic [sfp_pkg::ByteW-1:0]   payload_byte;
  logic [sfp_pkg::ByteW-1:0]   frame_id;
  logic [sfp_pkg::LenW-1:0]    frame_len;

  modport source (output valid, output status, output payload_byte, output frame_id,
                  output frame_len, input ready);
  modport sink   (input valid, input status, input payload_byte, input frame_id,
                  input frame_len, output ready);
endinterface

// File: sv/sfp_cfg_regs.sv
// APB register block holding the tag byte and the maximum payload length.
`timescale 1ns / 1ps

module sfp_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfp_pkg::AddrW-1:0]   paddr,
  input  logic [sfp_pkg::DataW-1:0]   pwdata,
  output logic [sfp_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output sfp_pkg::cfg_t               cfg_o
);

  logic [sfp_pkg::ByteW-1:0] tag_q;
  logic [sfp_pkg::LenW-1:0]  max_len_q;
  logic                      wr_en;
  sfp_pkg::reg_idx_e         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = sfp_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q     <= sfp_pkg::TagReset;
      max_len_q <= sfp_pkg::MaxLenReset;
    end else if (wr_en) begin
      unique case (idx)
        sfp_pkg::REG_TAG:     tag_q     <= pwdata[sfp_pkg::ByteW-1:0];
        sfp_pkg::REG_MAX_LEN: max_len_q <= pwdata[sfp_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sfp_pkg::REG_TAG:     prdata = {{(sfp_pkg::DataW-sfp_pkg::ByteW){1'b0}}, tag_q};
      sfp_pkg::REG_MAX_LEN: prdata = {{(sfp_pkg::DataW-sfp_pkg::LenW){1'b0}}, max_len_q};
      default:              prdata = '0;
    endcase
  end

  assign cfg_o.tag_byte        = tag_q;
  assign cfg_o.max_payload_len = max_len_q;

endmodule

// File: sv/sfp_decoder.sv
// Frame state and the single-pass decision logic applied to one received byte.
`timescale 1ns / 1ps

module sfp_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [sfp_pkg::ByteW-1:0] rx_byte_i,
  input  sfp_pkg::cfg_t             cfg_i,
  output sfp_pkg::res_t             res_o
);

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_ID   = 6'b000010,
    PH_LEN  = 6'b000100,
    PH_DATA = 6'b001000,
    PH_SUM  = 6'b010000,
    PH_DONE = 6'b100000
  } phase_e;

  phase_e                      phase_q, phase_d, ph;
  logic                        esc_q, esc_d, esc;
  logic [sfp_pkg::AccW-1:0]    len_q, len_d, len;
  logic [sfp_pkg::ShiftW-1:0]  shift_q, shift_d, shift;
  logic [sfp_pkg::LenW-1:0]    cnt_q, cnt_d, cnt, cnt_inc;
  logic [sfp_pkg::ByteW-1:0]   sum_q, sum_d, sum;
  logic [sfp_pkg::ByteW-1:0]   id_q, id_d;
  logic                        restart, fail, big, sat;
  logic [6:0]                  digit;
  logic [20:0]                 shifted;
  logic [21:0]                 acc;

  always_comb begin
    // The byte after a good frame first restarts the frame.
    restart = (phase_q == PH_DONE);
    ph      = restart ? PH_HUNT : phase_q;
    esc     = restart ? 1'b0 : esc_q;
    len     = restart ? '0 : len_q;
    shift   = restart ? '0 : shift_q;
    cnt     = restart ? '0 : cnt_q;
    sum     = restart ? '0 : sum_q;

    digit = rx_byte_i[6:0];
    big   = 1'b0;
    unique case (shift)
      3'd0:    shifted = {14'b0, digit};
      3'd1:    shifted = {7'b0, digit, 7'b0};
      3'd2:    shifted = {digit, 14'b0};
      default: begin
        shifted = '0;
        big     = (digit != 7'd0);
      end
    endcase
    acc     = {5'b0, len} + {1'b0, shifted};
    sat     = big || (acc > {5'b0, sfp_pkg::AccMax});
    cnt_inc = cnt + 16'd1;

    phase_d = ph;
    esc_d   = esc;
    len_d   = len;
    shift_d = shift;
    cnt_d   = cnt;
    sum_d   = sum;
    id_d    = id_q;
    fail    = 1'b0;
    res_o.status       = sfp_pkg::ST_CONSUMED;
    res_o.payload_byte = '0;

    if (ph == PH_HUNT) begin
      if (rx_byte_i != cfg_i.tag_byte) begin
        esc_d = 1'b0;
      end else if (esc) begin
        phase_d = PH_ID;
        esc_d   = 1'b0;
      end else begin
        esc_d = 1'b1;
      end
    end else if (esc) begin
      if (rx_byte_i == '0) begin
        esc_d = 1'b0;
      end else begin
        fail         = 1'b1;
        res_o.status = sfp_pkg::ST_BAD_ESC;
      end
    end else begin
      if (rx_byte_i == cfg_i.tag_byte) begin
        esc_d = 1'b1;
      end
      unique case (ph)
        PH_ID: begin
          sum_d   = sum + rx_byte_i;
          id_d    = rx_byte_i;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          sum_d = sum + rx_byte_i;
          len_d = sat ? sfp_pkg::AccMax : acc[sfp_pkg::AccW-1:0];
          if (!rx_byte_i[7]) begin
            phase_d = (len_d == '0) ? PH_SUM : PH_DATA;
          end else if (shift != 3'd7) begin
            shift_d = shift + 3'd1;
          end
          if (len_d > {1'b0, cfg_i.max_payload_len}) begin
            fail         = 1'b1;
            res_o.status = sfp_pkg::ST_LEN_LARGE;
          end
        end
        PH_DATA: begin
          sum_d              = sum + rx_byte_i;
          res_o.status       = sfp_pkg::ST_PAYLOAD;
          res_o.payload_byte = rx_byte_i;
          cnt_d              = cnt_inc;
          if ({1'b0, cnt_inc} >= len) begin
            phase_d = PH_SUM;
            cnt_d   = '0;
          end
        end
        default: begin
          if (rx_byte_i != sum) begin
            fail         = 1'b1;
            res_o.status = sfp_pkg::ST_CSUM_BAD;
          end else begin
            res_o.status = sfp_pkg::ST_GOOD;
            phase_d      = PH_DONE;
          end
        end
      endcase
    end

    // Reported values are taken before an abort clears the frame.
    res_o.frame_id  = id_d;
    res_o.frame_len = len_d[16] ? 16'hFFFF : len_d[sfp_pkg::LenW-1:0];

    if (fail) begin
      phase_d = PH_HUNT;
      esc_d   = 1'b0;
      len_d   = '0;
      shift_d = '0;
      cnt_d   = '0;
      sum_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      esc_q   <= 1'b0;
      len_q   <= '0;
      shift_q <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      id_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      len_q   <= len_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      id_q    <= id_d;
    end
  end

  a_fail_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && fail |=> phase_q == PH_HUNT && !esc_q && len_q == '0)
    else $error("aborted frame did not return to hunting");

  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> {1'b0, cnt_q} < len_q)
    else $error("payload byte count reached the declared length inside data");

  a_len_sat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HUNT |-> len_q == '0 && shift_q == '0 && cnt_q == '0)
    else $error("frame counters not clear while hunting");

endmodule

// File: sv/stuffed_frame_parser.sv
// Top level of the stuffed frame parser: input register, decoder and result register.
//
//   Port     Direction  Payload
//   rx_i     in         rx_byte (8 bits)
//   res_o    out        status (3), payload_byte (8), frame_id (8), frame_len (16)
//   APB      in/out     tag_byte at 0x0, max_payload_len at 0x4
//
// One item is taken per cycle unless a stalled result holds the input register.
// The frame decision for a byte sits between the input register and the result register.
// A stalled result holds the result register, and the input register then holds too.
// Reset clears the frame state, returns to hunting and restores the register defaults.
`timescale 1ns / 1ps

module stuffed_frame_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  sfp_rx_if.sink                    rx_i,
  sfp_res_if.source                 res_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sfp_pkg::AddrW-1:0] paddr,
  input  logic [sfp_pkg::DataW-1:0] pwdata,
  output logic [sfp_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  sfp_pkg::cfg_t             cfg;
  sfp_pkg::res_t             res, out_q;
  logic                      in_valid_q, out_valid_q;
  logic [sfp_pkg::ByteW-1:0] in_byte_q;
  logic                      adv, step;

  sfp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign adv        = !out_valid_q || res_o.ready;
  assign step       = in_valid_q && adv;
  assign rx_i.ready = !in_valid_q || adv;

  sfp_decoder u_dec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rx_i.ready) begin
        in_valid_q <= rx_i.valid;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.status       = out_q.status;
  assign res_o.payload_byte = out_q.payload_byte;
  assign res_o.frame_id     = out_q.frame_id;
  assign res_o.frame_len    = out_q.frame_len;

  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("processed item did not reach the result register");

  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != sfp_pkg::ST_PAYLOAD |-> out_q.payload_byte == '0)
    else $error("payload byte set on a non-payload result");

endmodule

// File: bench/stuffed_frame_parser_tb.sv
// Self-checking testbench of the stuffed frame parser: directed table, random frames, predictor.
`timescale 1ns / 1ps

module stuffed_frame_parser_tb;

  localparam int unsigned ByteW  = sfp_pkg::ByteW;
  localparam int unsigned LenW   = sfp_pkg::LenW;
  localparam int unsigned AccW   = sfp_pkg::AccW;
  localparam int unsigned ShiftW = sfp_pkg::ShiftW;
  localparam int unsigned AddrW  = sfp_pkg::AddrW;
  localparam int unsigned DataW  = sfp_pkg::DataW;

  localparam logic [2:0] FP_HUNT = 3'd0;
  localparam logic [2:0] FP_ID   = 3'd1;
  localparam logic [2:0] FP_LEN  = 3'd2;
  localparam logic [2:0] FP_DATA = 3'd3;
  localparam logic [2:0] FP_SUM  = 3'd4;
  localparam logic [2:0] FP_DONE = 3'd5;

  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned PhaseItems  = 240;
  localparam int unsigned PhaseCount  = 6;
  localparam int unsigned DirectedLen = 26;

  typedef struct packed {
    logic [ByteW-1:0] rx;
    logic             typed;
    sfp_pkg::res_t    want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  sfp_rx_if  rx_if ();
  sfp_res_if res_if ();

  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  stuffed_frame_parser DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Parser state and registers as the predictor sees them.
  logic [ByteW-1:0] cfg_tag;
  logic [LenW-1:0]  cfg_max;
  logic [2:0]       p_phase;
  logic             p_esc;
  logic [AccW-1:0]  p_acc;
  logic [ShiftW-1:0] p_shift;
  logic [LenW-1:0]  p_count;
  logic [ByteW-1:0] p_sum;
  logic [ByteW-1:0] p_id;

  sfp_pkg::res_t expected_results[$];
  int unsigned   errors;
  int unsigned   fed_bytes;
  int unsigned   stall_cycles;
  logic          calm;

  dir_row_t directed_rows [DirectedLen] = '{
    '{8'h00, 1'b1, '{sfp_pkg::ST_CONSUMED, 8'h00, 8'h00, 16'd0}},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h12, 1'b0, '0},
    '{8'h83, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h13, 1'b1, '{sfp_pkg::ST_GOOD, 8'h00, 8'h12, 16'd3}},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h05, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{sfp_pkg::ST_CSUM_BAD, 8'h00, 8'h05, 16'd0}},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h81, 1'b0, '0},
    '{8'h81, 1'b0, '0},
    '{8'h08, 1'b1, '{sfp_pkg::ST_LEN_LARGE, 8'h00, 8'h81, 16'd1025}},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h07, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h01, 1'b1, '{sfp_pkg::ST_BAD_ESC, 8'h00, 8'h07, 16'd127}}
  };

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  task automatic restart_frame();
    p_phase = FP_HUNT;
    p_esc   = 1'b0;
    p_acc   = '0;
    p_shift = '0;
    p_count = '0;
    p_sum   = '0;
  endtask

  task automatic parse_byte(input logic [ByteW-1:0] b, output sfp_pkg::res_t r);
    logic [63:0]      grown;
    sfp_pkg::status_e st;
    logic [ByteW-1:0] pay;
    logic             abort;
    st    = sfp_pkg::ST_CONSUMED;
    pay   = '0;
    abort = 1'b0;
    if (p_phase >= FP_DONE) restart_frame();
    if (p_phase == FP_HUNT) begin
      if (b != cfg_tag) begin
        p_esc = 1'b0;
      end else if (p_esc) begin
        p_phase = FP_ID;
        p_esc   = 1'b0;
      end else begin
        p_esc = 1'b1;
      end
    end else if (p_esc) begin
      if (b == 8'h00) begin
        p_esc = 1'b0;
      end else begin
        st    = sfp_pkg::ST_BAD_ESC;
        abort = 1'b1;
      end
    end else begin
      if (b == cfg_tag) p_esc = 1'b1;
      case (p_phase)
        FP_ID: begin
          p_sum   = p_sum + b;
          p_id    = b;
          p_phase = FP_LEN;
        end
        FP_LEN: begin
          grown = 64'(p_acc) + (64'(b[6:0]) << (7 * p_shift));
          p_sum = p_sum + b;
          p_acc = (grown > 64'(sfp_pkg::AccMax)) ? sfp_pkg::AccMax
                                                 : grown[AccW-1:0];
          if (!b[7]) begin
            p_phase = (p_acc == '0) ? FP_SUM : FP_DATA;
          end else if (p_shift < 3'd7) begin
            p_shift = p_shift + 1'b1;
          end
          if (p_acc > AccW'(cfg_max)) begin
            st    = sfp_pkg::ST_LEN_LARGE;
            abort = 1'b1;
          end
        end
        FP_DATA: begin
          p_sum   = p_sum + b;
          st      = sfp_pkg::ST_PAYLOAD;
          pay     = b;
          p_count = p_count + 1'b1;
          if (AccW'(p_count) >= p_acc) begin
            p_phase = FP_SUM;
            p_count = '0;
          end
        end
        default: begin
          if (b != p_sum) begin
            st    = sfp_pkg::ST_CSUM_BAD;
            abort = 1'b1;
          end else begin
            st      = sfp_pkg::ST_GOOD;
            p_phase = FP_DONE;
          end
        end
      endcase
    end
    r.status       = st;
    r.payload_byte = pay;
    r.frame_id     = p_id;
    r.frame_len    = (p_acc > 17'h0FFFF) ? 16'hFFFF : p_acc[LenW-1:0];
    if (abort) restart_frame();
  endtask

  task automatic feed_byte(input logic [ByteW-1:0] b, input logic typed,
                           input sfp_pkg::res_t want);
    sfp_pkg::res_t pred;
    if (!calm) begin
      while ($urandom_range(99) < 9) begin
        rx_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    parse_byte(b, pred);
    expected_results.push_back(typed ? want : pred);
    fed_bytes++;
  endtask

  task automatic feed_raw(input logic [ByteW-1:0] b);
    feed_byte(b, 1'b0, '0);
  endtask

  // A frame byte equal to the tag is followed by a stuffed zero.
  task automatic feed_stuffed(input logic [ByteW-1:0] b);
    feed_raw(b);
    if (b == cfg_tag) feed_raw(8'h00);
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) return cfg_tag;
    if (r == 1) return 8'h00;
    return ByteW'($urandom_range(255));
  endfunction

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(8, 1);
    repeat (n) feed_raw(pick_byte());
  endtask

  task automatic send_frame();
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] d;
    logic [ByteW-1:0] b;
    int unsigned      len;
    int unsigned      v;
    int unsigned      pad;
    int unsigned      pick;
    int unsigned      bad_at;
    logic             over;
    logic             saturate;
    logic             tag_sum;
    pick     = $urandom_range(99);
    pad      = 0;
    over     = 1'b0;
    saturate = 1'b0;
    if (pick < 12) begin
      len = 0;
    end else if (pick < 65) begin
      len = $urandom_range(12, 1);
    end else if (pick < 80) begin
      len = $urandom_range(64, 13);
    end else if (pick < 88) begin
      len  = int'(cfg_max) + $urandom_range(300, 1);
      over = 1'b1;
    end else if (pick < 95) begin
      len = $urandom_range(20);
      pad = $urandom_range(10, 1);
    end else begin
      len      = $urandom_range(20);
      pad      = $urandom_range(11, 9);
      saturate = 1'b1;
      over     = 1'b1;
    end
    if (!over && len > int'(cfg_max)) len = cfg_max;
    feed_raw(cfg_tag);
    feed_raw(cfg_tag);
    b   = ByteW'($urandom_range(255));
    sum = b;
    feed_stuffed(b);
    v = len;
    do begin
      d = ByteW'(v & 32'h7F);
      v = v >> 7;
      if (v != 0 || pad != 0) d = d | 8'h80;
      sum = sum + d;
      feed_stuffed(d);
    end while (v != 0);
    for (int unsigned i = 0; i < pad; i++) begin
      d   = (i == pad - 1) ? (saturate ? 8'h01 : 8'h00) : 8'h80;
      sum = sum + d;
      feed_stuffed(d);
    end
    if (over) return;
    bad_at  = (len > 0 && $urandom_range(99) < 6) ? $urandom_range(len - 1) : len;
    tag_sum = ($urandom_range(9) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if (i == bad_at) begin
        feed_raw(cfg_tag);
        feed_raw(ByteW'($urandom_range(255, 1)));
        return;
      end
      b = pick_byte();
      if (tag_sum && i == len - 1) b = cfg_tag - sum;
      sum = sum + b;
      feed_stuffed(b);
    end
    if ($urandom_range(99) < 8) sum = sum + ByteW'($urandom_range(255, 1));
    feed_stuffed(sum);
  endtask

  task automatic write_reg(input sfp_pkg::reg_idx_e idx, input logic [DataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sfp_pkg::REG_TAG:     cfg_tag = value[ByteW-1:0];
      sfp_pkg::REG_MAX_LEN: cfg_max = value[LenW-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    rx_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    sfp_pkg::res_t got;
    sfp_pkg::res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = '{sfp_pkg::status_e'(res_if.status), res_if.payload_byte, res_if.frame_id,
              res_if.frame_len};
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: st=%0d pay=%02h id=%02h len=%0d",
                 $time, got.status, got.payload_byte, got.frame_id, got.frame_len);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.payload_byte !== want.payload_byte ||
            got.frame_id !== want.frame_id || got.frame_len !== want.frame_len) begin
          errors++;
          $display("%0t: expected st/pay/id/len %0d/%02h/%02h/%0d, got %0d/%02h/%02h/%0d",
                   $time, want.status, want.payload_byte, want.frame_id, want.frame_len,
                   got.status, got.payload_byte, got.frame_id, got.frame_len);
        end
      end
    end
    res_if.ready <= calm || ($urandom_range(99) >= 9);
  end

  always @(posedge clk_i) begin
    if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned      phase_start;
    logic [ByteW-1:0] tag_set;
    logic [LenW-1:0]  max_set;
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    errors        = 0;
    fed_bytes     = 0;
    stall_cycles  = 0;
    calm          = 1'b0;
    cfg_tag       = sfp_pkg::TagReset;
    cfg_max       = sfp_pkg::MaxLenReset;
    p_id          = '0;
    restart_frame();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < DirectedLen; i++) begin
      feed_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
    end
    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      settle();
      case (ph)
        1: begin tag_set = 8'h00; max_set = 16'hFFFF; end
        2: begin tag_set = 8'hA5; max_set = 16'h0000; end
        3: begin tag_set = 8'h7E; max_set = 16'd40; end
        4: begin
          tag_set = ByteW'($urandom_range(255));
          max_set = LenW'($urandom_range(200, 1));
        end
        default: begin tag_set = sfp_pkg::TagReset; max_set = sfp_pkg::MaxLenReset; end
      endcase
      if (ph != 0) begin
        write_reg(sfp_pkg::REG_TAG, DataW'(tag_set));
        write_reg(sfp_pkg::REG_MAX_LEN, DataW'(max_set));
      end
      calm        = (ph == 3);
      phase_start = fed_bytes;
      while (fed_bytes - phase_start < PhaseItems) begin
        if ($urandom_range(99) < 80) send_frame();
        else send_noise();
      end
    end
    calm = 1'b0;
    settle();
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
